>>> rtl/cmfs_pkg.sv
// ----------------------------------------------------------------------------
// cmfs_pkg: shared definitions for the cube map face select unit
// Field widths, derived datapath widths and the face codes.
// ----------------------------------------------------------------------------
package cmfs_pkg;

	localparam int DIR_BITS   = 16;
	localparam int COORD_BITS = 16;

	// Signed working width: holds the negated most negative component and sums.
	localparam int WORK_BITS  = DIR_BITS + 2;

	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

endpackage

>>> rtl/cube_map_face_select_unit.sv
// ----------------------------------------------------------------------------
// cube_map_face_select_unit: cube map face and face coordinate selection
// Picks the face of a direction vector and the two coordinates on that face.
// ----------------------------------------------------------------------------
// The unit takes one direction beat per cycle unless a stall reaches the input,
// and returns one result beat per direction, in order, after the selection
// stage and the divider stages. The first stage selects the major axis, its
// sign and the two minor components; each following stage of the radix-2 long
// divider produces one quotient bit of both coordinates, so the divider depth
// sets the latency. A stall backs up only the full stages, and empty stages
// keep filling.
module cube_map_face_select_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   dir_valid,
	output logic                                   dir_ready,
	input  logic signed [cmfs_pkg::DIR_BITS-1:0]   dir_x,
	input  logic signed [cmfs_pkg::DIR_BITS-1:0]   dir_y,
	input  logic signed [cmfs_pkg::DIR_BITS-1:0]   dir_z,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic [2:0]                             face,
	output logic [cmfs_pkg::COORD_BITS-1:0]        coord_u,
	output logic [cmfs_pkg::COORD_BITS-1:0]        coord_v,
	output logic                                   hit
);

	localparam int SW = cmfs_pkg::WORK_BITS;
	localparam int CB = cmfs_pkg::COORD_BITS;
	localparam int DB = cmfs_pkg::DIR_BITS;

	logic signed [SW-1:0] ex, ey, ez;
	logic signed [SW-1:0] ax, ay, az;
	logic signed [SW-1:0] major, minor_u, minor_v;
	logic signed [SW-1:0] num_u, num_v;
	logic                 sel_hit;
	cmfs_pkg::face_t      sel_face;

	logic                 valid_s [0:CB];
	logic                 rdy     [0:CB+1];
	logic [SW-1:0]        rem_u_s [0:CB];
	logic [SW-1:0]        rem_v_s [0:CB];
	logic [SW-1:0]        den_s   [0:CB];
	logic [CB-1:0]        quo_u_s [0:CB];
	logic [CB-1:0]        quo_v_s [0:CB];
	cmfs_pkg::face_t      face_s  [0:CB];
	logic                 hit_s   [0:CB];

	always_comb begin
		ex = SW'(dir_x);
		ey = SW'(dir_y);
		ez = SW'(dir_z);
		ax = (ex < 0) ? -ex : ex;
		ay = (ey < 0) ? -ey : ey;
		az = (ez < 0) ? -ez : ez;
		sel_hit  = 1'b1;
		sel_face = cmfs_pkg::FACE_POS_X;
		major    = ax;
		minor_u  = '0;
		minor_v  = '0;
		if (ax > ay && ax > az) begin
			major    = ax;
			sel_face = (ex > 0) ? cmfs_pkg::FACE_POS_X : cmfs_pkg::FACE_NEG_X;
			minor_u  = (ex > 0) ? -ez : ez;
			minor_v  = ey;
		end else if (ay > ax && ay > az) begin
			major    = ay;
			sel_face = (ey > 0) ? cmfs_pkg::FACE_POS_Y : cmfs_pkg::FACE_NEG_Y;
			minor_u  = ex;
			minor_v  = (ey > 0) ? -ez : ez;
		end else if (az > ax && az > ay) begin
			major    = az;
			sel_face = (ez > 0) ? cmfs_pkg::FACE_POS_Z : cmfs_pkg::FACE_NEG_Z;
			minor_u  = (ez > 0) ? ex : -ex;
			minor_v  = ey;
		end else begin
			sel_hit  = 1'b0;
		end
		num_u = sel_hit ? (minor_u + major) : '0;
		num_v = sel_hit ? (minor_v + major) : '0;
	end

	assign rdy[CB+1] = res_ready;

	for (genvar k = 0; k <= CB; k++) begin : g_rdy
		assign rdy[k] = !valid_s[k] || rdy[k+1];
	end

	assign dir_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			valid_s[0] <= dir_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			rem_u_s[0] <= num_u;
			rem_v_s[0] <= num_v;
			den_s[0]   <= sel_hit ? {major[SW-2:0], 1'b0} : SW'(1);
			quo_u_s[0] <= '0;
			quo_v_s[0] <= '0;
			face_s[0]  <= sel_hit ? sel_face : cmfs_pkg::FACE_POS_X;
			hit_s[0]   <= sel_hit;
		end
	end

	for (genvar k = 1; k <= CB; k++) begin : g_div
		logic [SW-1:0] two_u, two_v;
		logic          bit_u, bit_v;

		always_comb begin
			two_u = {rem_u_s[k-1][SW-2:0], 1'b0};
			two_v = {rem_v_s[k-1][SW-2:0], 1'b0};
			bit_u = (two_u >= den_s[k-1]);
			bit_v = (two_v >= den_s[k-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_u_s[k] <= bit_u ? (two_u - den_s[k-1]) : two_u;
				rem_v_s[k] <= bit_v ? (two_v - den_s[k-1]) : two_v;
				den_s[k]   <= den_s[k-1];
				quo_u_s[k] <= {quo_u_s[k-1][CB-2:0], bit_u};
				quo_v_s[k] <= {quo_v_s[k-1][CB-2:0], bit_v};
				face_s[k]  <= face_s[k-1];
				hit_s[k]   <= hit_s[k-1];
			end
		end
	end

	assign res_valid = valid_s[CB];
	assign face      = face_s[CB];
	assign coord_u   = quo_u_s[CB];
	assign coord_v   = quo_v_s[CB];
	assign hit       = hit_s[CB];

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !hit) |->
			(face == cmfs_pkg::FACE_POS_X && coord_u == '0 && coord_v == '0))
		else $error("miss beat carries nonzero fields");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> dir_ready)
		else $error("pipeline refuses a beat while the output drains");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] |-> (rem_u_s[0] < den_s[0] && rem_v_s[0] < den_s[0]))
		else $error("numerator not below divisor at divider entry");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (face <= cmfs_pkg::FACE_NEG_Z && den_s[CB] != '0 && DB >= 8))
		else $error("bad face code or zero divisor at output");

endmodule

>>> test/cube_map_face_select_unit_tb.sv
// ----------------------------------------------------------------------------
// cube_map_face_select_unit_tb: self-checking bench for face selection
// Sends directions through the valid/ready input and predicts face, face
// coordinates and hit for each accepted beat. Result beats are checked in
// order against the predictions; each phase sets the random idle share of each side.
// ----------------------------------------------------------------------------
module cube_map_face_select_unit_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;

	typedef logic signed [cmfs_pkg::DIR_BITS-1:0] dir_comp_t;

	typedef struct {
		cmfs_pkg::face_t                 face;
		logic [cmfs_pkg::COORD_BITS-1:0] u;
		logic [cmfs_pkg::COORD_BITS-1:0] v;
		logic                            hit;
	} face_hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic dir_valid = 1'b0;
	logic dir_ready;
	dir_comp_t dir_x = '0;
	dir_comp_t dir_y = '0;
	dir_comp_t dir_z = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [2:0] face;
	logic [cmfs_pkg::COORD_BITS-1:0] coord_u;
	logic [cmfs_pkg::COORD_BITS-1:0] coord_v;
	logic hit;

	face_hit_t pending_faces[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	cube_map_face_select_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.dir_valid (dir_valid),
		.dir_ready (dir_ready),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.face      (face),
		.coord_u   (coord_u),
		.coord_v   (coord_v),
		.hit       (hit)
	);

	always #2 clk = ~clk;

	function automatic logic [cmfs_pkg::COORD_BITS-1:0] face_coordinate(longint m, longint a);
		longint quotient;
		quotient = ((m + a) <<< cmfs_pkg::COORD_BITS) / (2 * a);
		return quotient[cmfs_pkg::COORD_BITS-1:0];
	endfunction

	function automatic face_hit_t predict_face(dir_comp_t x, dir_comp_t y, dir_comp_t z);
		face_hit_t r;
		longint sx, sy, sz, ax, ay, az;
		sx = x;
		sy = y;
		sz = z;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		az = (sz < 0) ? -sz : sz;
		r.face = cmfs_pkg::FACE_POS_X;
		r.u = '0;
		r.v = '0;
		r.hit = 1'b1;
		if (ax > ay && ax > az) begin
			r.face = (sx > 0) ? cmfs_pkg::FACE_POS_X : cmfs_pkg::FACE_NEG_X;
			r.u = face_coordinate((sx > 0) ? -sz : sz, ax);
			r.v = face_coordinate(sy, ax);
		end else if (ay > ax && ay > az) begin
			r.face = (sy > 0) ? cmfs_pkg::FACE_POS_Y : cmfs_pkg::FACE_NEG_Y;
			r.u = face_coordinate(sx, ay);
			r.v = face_coordinate((sy > 0) ? -sz : sz, ay);
		end else if (az > ax && az > ay) begin
			r.face = (sz > 0) ? cmfs_pkg::FACE_POS_Z : cmfs_pkg::FACE_NEG_Z;
			r.u = face_coordinate((sz > 0) ? sx : -sx, az);
			r.v = face_coordinate(sy, az);
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0d] %s: got %0d, expected %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Result side: random stalls and in-order comparison of every result beat.
	always @(posedge clk) begin
		face_hit_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_faces.size() == 0) begin
				report_mismatch("result beat with nothing pending", face, -1);
			end else begin
				want = pending_faces.pop_front();
				if (face !== want.face)
					report_mismatch("face", face, want.face);
				if (coord_u !== want.u)
					report_mismatch("coord_u", coord_u, want.u);
				if (coord_v !== want.v)
					report_mismatch("coord_v", coord_v, want.v);
				if (hit !== want.hit)
					report_mismatch("hit", hit, want.hit);
			end
		end
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_dir(dir_comp_t x, dir_comp_t y, dir_comp_t z);
		while ($urandom_range(99) < send_idle_pct) begin
			dir_valid <= 1'b0;
			@(posedge clk);
		end
		dir_valid <= 1'b1;
		dir_x <= x;
		dir_y <= y;
		dir_z <= z;
		pending_faces.push_back(predict_face(x, y, z));
		do
			@(posedge clk);
		while (!dir_ready);
	endtask

	task automatic wait_drained();
		dir_valid <= 1'b0;
		while (pending_faces.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_minor(int major_mag);
		int r;
		case ($urandom_range(7))
			0: r = major_mag - 1;
			1: r = -(major_mag - 1);
			default: begin
				r = $urandom_range(major_mag - 1);
				if ($urandom_range(1))
					r = -r;
			end
		endcase
		return r;
	endfunction

	function automatic int pick_magnitude();
		int k;
		int m;
		k = $urandom_range(15);
		m = $urandom_range((2 << k) - 1) + 1;
		return (m > 32768) ? 32768 : m;
	endfunction

	task automatic test_directed_corners();
		send_dir(32767, 0, 0);
		send_dir(-32768, 0, 0);
		send_dir(0, 32767, 0);
		send_dir(0, -32768, 0);
		send_dir(0, 0, 32767);
		send_dir(0, 0, -32768);
		send_dir(-32768, 32767, -32767);
		send_dir(-32768, -32767, 32767);
		send_dir(32767, -32766, 32766);
		send_dir(32767, -32768, 32767);
		send_dir(-32767, 32767, -32768);
		send_dir(1, 0, 0);
		send_dir(0, -1, 0);
		send_dir(-1, 1, -2);
		send_dir(2, 1, -1);
		send_dir(100, -99, 99);
		send_dir(0, 0, 0);
		send_dir(-32768, -32768, 0);
		send_dir(-32768, -32768, -32768);
		send_dir(32767, -32767, 32767);
		send_dir(7, -7, 3);
		send_dir(5, 2, -5);
		send_dir(1, -3, 3);
		send_dir(16'sh5555, -16'sh2aab, 16'sh2aaa);
		wait_drained();
	endtask

	task automatic test_random_directions(int count);
		repeat (count)
			send_dir(dir_comp_t'($urandom), dir_comp_t'($urandom), dir_comp_t'($urandom));
	endtask

	task automatic test_dominant_axis(int count);
		int axis;
		int major_mag;
		int comp[3];
		repeat (count) begin
			axis = $urandom_range(2);
			major_mag = pick_magnitude();
			comp[axis] = (major_mag == 32768 || $urandom_range(1)) ? -major_mag : major_mag;
			comp[(axis + 1) % 3] = pick_minor(major_mag);
			comp[(axis + 2) % 3] = pick_minor(major_mag);
			send_dir(comp[0], comp[1], comp[2]);
		end
	endtask

	task automatic test_tied_axes(int count);
		int skip;
		int tie_mag;
		int rest;
		int comp[3];
		repeat (count) begin
			skip = $urandom_range(2);
			tie_mag = ($urandom_range(7) == 0) ? 0 : pick_magnitude();
			for (int i = 0; i < 3; i++)
				comp[i] = (tie_mag == 32768 || $urandom_range(1)) ? -tie_mag : tie_mag;
			rest = (tie_mag == 0) ? 0 : $urandom_range(tie_mag);
			if (rest == 32768 || $urandom_range(1))
				rest = -rest;
			comp[skip] = rest;
			send_dir(comp[0], comp[1], comp[2]);
		end
	endtask

	task automatic run_mixed_phase(int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		test_random_directions(150);
		test_dominant_axis(200);
		test_tied_axes(70);
		wait_drained();
		test_dominant_axis(150);
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 21;
		recv_idle_pct = 70;
		test_directed_corners();
		run_mixed_phase(21, 70);
		run_mixed_phase(70, 21);
		run_mixed_phase(0, 0);
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && pending_faces.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> cube_map_face_select_unit.f
rtl/cmfs_pkg.sv
rtl/cube_map_face_select_unit.sv
test/cube_map_face_select_unit_tb.sv
